// ===== sv/zpg_pkg.sv =====
// package: shared constants and codes of the zone plate pixel generator
`timescale 1ns / 1ps
package zpg_pkg;

  // default parameter values
  localparam int COS_TABLE_DEPTH_DEF = 1024;
  localparam int COORD_BITS_DEF      = 13;

  // register widths
  localparam int CFG_IDX_BITS  = 3;
  localparam int CFG_DATA_BITS = 20;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_WIDTH           = 3'd0,
    CFG_HEIGHT          = 3'd1,
    CFG_FRAME_LAST      = 3'd2,
    CFG_RADIUS_SCALE_SQ = 3'd3,
    CFG_AMPLITUDE       = 3'd4
  } cfg_idx_e;

  // register reset values
  localparam logic [13:0] WIDTH_RST           = 14'd4096;
  localparam logic [13:0] HEIGHT_RST          = 14'd2160;
  localparam logic [7:0]  FRAME_LAST_RST      = 8'd5;
  localparam logic [19:0] RADIUS_SCALE_SQ_RST = 20'd65536;
  localparam logic [15:0] AMPLITUDE_RST       = 16'd40807;

  // ring divisor D in q.8: base 2160, span 1936
  localparam logic [20:0] D_BASE_Q8 = 21'd552960;
  localparam logic [18:0] D_SPAN_Q8 = 19'd495616;

  // per-channel gains in q16
  localparam logic [16:0] GAIN_RED   = 17'd62289;
  localparam logic [16:0] GAIN_GREEN = 17'd65536;
  localparam logic [16:0] GAIN_BLUE  = 17'd71372;

  // pi in q30 and the sine series divisors (2k)(2k+1)
  localparam longint unsigned PI_Q30 = 64'd3373259426;
  localparam longint unsigned SERIES_DIV [10] = '{
    64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156, 64'd210, 64'd272, 64'd342, 64'd420
  };

endpackage

// ===== sv/zone_plate_pixel_generator.sv =====
// top level: pipelined animated circular zone plate pixel generator
`timescale 1ns / 1ps
// usage
//   input channel (in_valid_i / in_ready_o) takes one word per cycle while
//   ready: pixel column x_i, line y_i and frame_index_i. output channel
//   (out_valid_o / out_ready_i) returns one rgb word per input word, in order.
//   config channel (cfg_valid_i / cfg_ready_o, always ready) writes register
//   cfg_index_i with cfg_data_i: width, height, frame_last, radius_scale_sq,
//   amplitude. write only while the pipeline is empty. unknown index is ignored.
// throughput: one word per cycle while out_ready_i is high.
// pipeline: stages a to c, the 19-step ring divisor division, stage e, the
//   QW-step phase division (one quotient bit per stage) and the table and gain
//   stages f to j, all registered between accept and out_valid_o.
// reset: all valid bits clear, config registers take their reset values.
// stall: the whole pipeline holds while out_valid_o is high and out_ready_i is
//   low; in_ready_o drops in that cycle, so nothing is lost or repeated.
module zone_plate_pixel_generator #(
  parameter int COS_TABLE_DEPTH = zpg_pkg::COS_TABLE_DEPTH_DEF,
  parameter int COORD_BITS      = zpg_pkg::COORD_BITS_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [zpg_pkg::CFG_IDX_BITS-1:0]  cfg_index_i,
  input  logic [zpg_pkg::CFG_DATA_BITS-1:0] cfg_data_i,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic [COORD_BITS-1:0]            x_i,
  input  logic [COORD_BITS-1:0]            y_i,
  input  logic [7:0]                       frame_index_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [15:0]                      red_o,
  output logic [15:0]                      green_o,
  output logic [15:0]                      blue_o
);
  import zpg_pkg::*;

  // doubled offset width, sum of squares, product, numerator, quotient bits
  localparam int DW  = (((COORD_BITS + 1) > 14) ? (COORD_BITS + 1) : 14) + 1;
  localparam int SW  = 2 * DW - 1;
  localparam int PW  = 20 + SW;
  localparam int NW  = PW + 6;
  localparam int QW  = NW - 19;   // D is at least 2^19
  localparam int DQ  = 19;        // ring divisor quotient bits
  localparam int DRW = 27;        // ring divisor numerator bits
  localparam int IW  = $clog2(COS_TABLE_DEPTH);

  // ---------------------------------------------------------------- level table
  function automatic logic [15:0] level_entry(input longint unsigned i);
    longint unsigned j, t, t2, term, s, v;
    longint          acc;
    j = (i > COS_TABLE_DEPTH - i) ? (COS_TABLE_DEPTH - i) : i;
    t = (PI_Q30 * j) / COS_TABLE_DEPTH;
    t2 = (t * t) >> 30;
    term = t;
    acc = longint'(t);
    for (int k = 1; k <= 10; k++) begin
      term = ((term * t2) >> 30) / SERIES_DIV[k-1];
      if (k[0]) begin
        acc = acc - longint'(term);
      end else begin
        acc = acc + longint'(term);
      end
    end
    if (acc < 0) begin
      acc = 0;
    end
    s = longint'(unsigned'(acc));
    v = (s * s + (64'd1 << 43)) >> 44;
    return (v > 64'd65535) ? 16'hFFFF : v[15:0];
  endfunction

  logic [15:0] lvl_rom [COS_TABLE_DEPTH];
  for (genvar g = 0; g < COS_TABLE_DEPTH; g++) begin : g_rom
    assign lvl_rom[g] = level_entry(g);
  end

  // ---------------------------------------------------------------- config
  logic [13:0] width_q, height_q;
  logic [7:0]  frame_last_q;
  logic [19:0] rs_q;
  logic [15:0] amp_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q      <= WIDTH_RST;
      height_q     <= HEIGHT_RST;
      frame_last_q <= FRAME_LAST_RST;
      rs_q         <= RADIUS_SCALE_SQ_RST;
      amp_q        <= AMPLITUDE_RST;
    end else if (cfg_valid_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_WIDTH:           width_q      <= cfg_data_i[13:0];
        CFG_HEIGHT:          height_q     <= cfg_data_i[13:0];
        CFG_FRAME_LAST:      frame_last_q <= cfg_data_i[7:0];
        CFG_RADIUS_SCALE_SQ: rs_q         <= cfg_data_i[19:0];
        CFG_AMPLITUDE:       amp_q        <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------- flow control
  // whole pipeline advances unless the output word is stalled
  logic en;
  assign en         = !out_valid_o || out_ready_i;
  assign in_ready_o = en;

  // ---------------------------------------------------------------- stage a: offsets
  logic                 a_v_q;
  logic signed [DW-1:0] a_dx_q, a_dy_q, a_dx_d, a_dy_d;
  logic [7:0]           a_f_q, a_f_d;

  assign a_dx_d = signed'(DW'({x_i, 1'b0})) - signed'(DW'(width_q));
  assign a_dy_d = signed'(DW'({y_i, 1'b0})) - signed'(DW'(height_q));
  // frame clamped to the last frame of the sweep
  assign a_f_d  = (frame_index_i > frame_last_q) ? frame_last_q : frame_index_i;

  // ---------------------------------------------------------------- stage b: squares
  logic                   b_v_q;
  logic [SW-2:0]          b_sqx_q, b_sqy_q;
  logic [DRW-1:0]         b_na_q, b_na_d;
  logic signed [2*DW-1:0] px, py;

  assign px     = a_dx_q * a_dx_q;
  assign py     = a_dy_q * a_dy_q;
  assign b_na_d = DRW'(DRW'(D_SPAN_Q8) * DRW'(a_f_q)) + DRW'(frame_last_q >> 1);

  // ---------------------------------------------------------------- stage c: radius^2
  logic           c_v_q;
  logic [SW-1:0]  c_s4_q;
  logic [DRW-1:0] c_na_q;

  // ---------------------------------------------------------------- ring divisor division
  typedef struct packed {
    logic [DRW-1:0] rem;
    logic [DQ-1:0]  q;
    logic [PW-1:0]  prod;
  } dd_t;

  logic [DQ-1:0] dd_v_q;
  dd_t           dd_q [DQ];
  dd_t           dd_d [DQ];

  always_comb begin
    dd_t src;
    for (int k = 0; k < DQ; k++) begin
      if (k == 0) begin
        src.rem  = c_na_q;
        src.q    = '0;
        src.prod = PW'(PW'(rs_q) * PW'(c_s4_q));
      end else begin
        src = dd_q[k-1];
      end
      dd_d[k] = src;
      if ((src.rem >> (DQ - 1 - k)) >= DRW'(frame_last_q)) begin
        dd_d[k].rem = src.rem - (DRW'(frame_last_q) << (DQ - 1 - k));
        dd_d[k].q   = src.q | (DQ'(1) << (DQ - 1 - k));
      end
    end
  end

  // ---------------------------------------------------------------- stage e: D and numerator
  logic          e_v_q;
  logic [20:0]   e_d_q, e_d_d;
  logic [NW-1:0] e_n_q, e_n_d;

  // zero frame_last gives the base divisor
  assign e_d_d = D_BASE_Q8 + ((frame_last_q == 8'd0) ? 21'd0 : 21'(dd_q[DQ-1].q));
  assign e_n_d = {dd_q[DQ-1].prod, 6'd0};

  // ---------------------------------------------------------------- phase division
  typedef struct packed {
    logic [NW-1:0] rem;
    logic [20:0]   d;
    logic [15:0]   q;
  } md_t;

  logic [QW-1:0] md_v_q;
  md_t           md_q [QW];
  md_t           md_d [QW];

  // only the low 16 quotient bits (phase fraction) are kept
  always_comb begin
    md_t src;
    for (int k = 0; k < QW; k++) begin
      if (k == 0) begin
        src.rem = e_n_q;
        src.d   = e_d_q;
        src.q   = '0;
      end else begin
        src = md_q[k-1];
      end
      md_d[k]   = src;
      md_d[k].q = {src.q[14:0], 1'b0};
      if ((src.rem >> (QW - 1 - k)) >= NW'(src.d)) begin
        md_d[k].rem = src.rem - (NW'(src.d) << (QW - 1 - k));
        md_d[k].q   = {src.q[14:0], 1'b1};
      end
    end
  end

  // ---------------------------------------------------------------- stage f: table index
  logic          f_v_q;
  logic [IW-1:0] f_idx_q, f_idx_d;
  logic [31:0]   f_scaled;

  assign f_scaled = 32'(md_q[QW-1].q) * 32'(COS_TABLE_DEPTH);
  assign f_idx_d  = f_scaled[16 +: IW];

  // ---------------------------------------------------------------- stages g..j: level and gains
  logic        g_v_q, h_v_q, i_v_q, j_v_q;
  logic [15:0] g_lvl_q;
  logic [31:0] h_at_q;
  logic [48:0] i_r_q, i_g_q, i_b_q;
  logic [15:0] j_r_q, j_g_q, j_b_q;

  function automatic logic [15:0] round_sat(input logic [48:0] p);
    logic [49:0] s;
    s = 50'(p) + (50'd1 << 31);
    return (s[49:32] > 18'd65535) ? 16'hFFFF : s[47:32];
  endfunction

  // ---------------------------------------------------------------- valid chain
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_v_q  <= 1'b0;
      b_v_q  <= 1'b0;
      c_v_q  <= 1'b0;
      dd_v_q <= '0;
      e_v_q  <= 1'b0;
      md_v_q <= '0;
      f_v_q  <= 1'b0;
      g_v_q  <= 1'b0;
      h_v_q  <= 1'b0;
      i_v_q  <= 1'b0;
      j_v_q  <= 1'b0;
    end else if (en) begin
      a_v_q  <= in_valid_i;
      b_v_q  <= a_v_q;
      c_v_q  <= b_v_q;
      dd_v_q <= {dd_v_q[DQ-2:0], c_v_q};
      e_v_q  <= dd_v_q[DQ-1];
      md_v_q <= {md_v_q[QW-2:0], e_v_q};
      f_v_q  <= md_v_q[QW-1];
      g_v_q  <= f_v_q;
      h_v_q  <= g_v_q;
      i_v_q  <= h_v_q;
      j_v_q  <= i_v_q;
    end
  end

  // ---------------------------------------------------------------- payload
  always_ff @(posedge clk_i) begin
    if (en) begin
      a_dx_q  <= a_dx_d;
      a_dy_q  <= a_dy_d;
      a_f_q   <= a_f_d;
      b_sqx_q <= px[SW-2:0];
      b_sqy_q <= py[SW-2:0];
      b_na_q  <= b_na_d;
      c_s4_q  <= SW'(b_sqx_q) + SW'(b_sqy_q);
      c_na_q  <= b_na_q;
      for (int k = 0; k < DQ; k++) begin
        dd_q[k] <= dd_d[k];
      end
      e_d_q   <= e_d_d;
      e_n_q   <= e_n_d;
      for (int k = 0; k < QW; k++) begin
        md_q[k] <= md_d[k];
      end
      f_idx_q <= f_idx_d;
      g_lvl_q <= lvl_rom[f_idx_q];
      h_at_q  <= 32'(amp_q) * 32'(g_lvl_q);
      i_r_q   <= 49'(h_at_q) * 49'(GAIN_RED);
      i_g_q   <= 49'(h_at_q) * 49'(GAIN_GREEN);
      i_b_q   <= 49'(h_at_q) * 49'(GAIN_BLUE);
      j_r_q   <= round_sat(i_r_q);
      j_g_q   <= round_sat(i_g_q);
      j_b_q   <= round_sat(i_b_q);
    end
  end

  assign out_valid_o = j_v_q;
  assign red_o       = j_r_q;
  assign green_o     = j_g_q;
  assign blue_o      = j_b_q;

endmodule

// ===== sv/zpg_checker.sv =====
// checker: port-level assertions for the zone plate pixel generator
`timescale 1ns / 1ps
module zpg_port_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_ready_o,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [15:0] red_o,
  input logic [15:0] green_o,
  input logic [15:0] blue_o
);

  // no output word during reset
  a_rst_quiet: assert property (@(posedge clk_i) !rst_ni |-> !out_valid_o)
    else $error("output valid during reset");

  // input side stalls exactly when the output word is stalled
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o == (!out_valid_o || out_ready_i))
    else $error("input ready does not follow output stall");

  // a stalled output word stays
  a_hold_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("output word dropped while stalled");

  // and keeps its payload
  a_hold_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(red_o) && $stable(green_o) && $stable(blue_o))
    else $error("output payload changed while stalled");

endmodule

bind zone_plate_pixel_generator zpg_port_checker u_zpg_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .red_o       (red_o),
  .green_o     (green_o),
  .blue_o      (blue_o)
);
